// ----- hdl/apq_pkg.sv -----
// Shared types and codes for the aging priority ready queue.
package apq_pkg;

  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_DEQUEUE = 1'b1
  } action_e;

  typedef enum logic {
    POLICY_RR   = 1'b0,
    POLICY_PRIO = 1'b1
  } policy_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] thread_id;
    logic [3:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic       granted;
    logic [7:0] chosen_id;
    status_e    status;
    logic [5:0] occupancy;
  } out_item_t;

  // One stored thread entry.
  typedef struct packed {
    logic [7:0] id;
    logic [3:0] prio;
    logic [7:0] age;
  } entry_t;

  // Running best candidate handed from cell to cell.
  typedef struct packed {
    logic       found;
    logic [8:0] score;
    logic [7:0] id;
  } token_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic       enq_en;
    logic       deq_en;
    logic       age_en;
    logic [7:0] new_id;
    logic [3:0] new_prio;
  } cell_ctrl_t;

endpackage

// ----- hdl/apq_cell.sv -----
// One queue slot: holds an entry, shifts toward the head on removal and
// forwards the best priority+age candidate seen so far to its neighbor.
module apq_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned POS_W = 5,
  parameter int unsigned CNT_W = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  apq_pkg::cell_ctrl_t ctrl_i,
  input  logic [POS_W-1:0]    pick_pos_i,
  input  logic [CNT_W-1:0]    count_i,
  input  apq_pkg::entry_t     next_entry_i,
  output apq_pkg::entry_t     entry_o,
  input  apq_pkg::token_t     tok_i,
  input  logic [POS_W-1:0]    tok_pos_i,
  output apq_pkg::token_t     tok_o,
  output logic [POS_W-1:0]    tok_pos_o
);

  apq_pkg::entry_t   entry_q, entry_d;
  apq_pkg::entry_t   base;
  apq_pkg::token_t   tok_q, tok_d;
  logic [POS_W-1:0]  tok_pos_q, tok_pos_d;
  logic              occupied;
  logic [8:0]        own_score;

  assign occupied  = count_i > CNT_W'(INDEX);
  assign own_score = {1'b0, entry_q.age} + {5'b0, entry_q.prio};

  always_comb begin
    base = entry_q;
    if (ctrl_i.deq_en && (POS_W'(INDEX) >= pick_pos_i)) begin
      base = next_entry_i;
    end
    if (ctrl_i.age_en && (base.age != 8'hFF)) begin
      base.age = base.age + 8'd1;
    end
    entry_d = base;
    if (ctrl_i.enq_en && (count_i == CNT_W'(INDEX))) begin
      entry_d = '{id: ctrl_i.new_id, prio: ctrl_i.new_prio, age: 8'd0};
    end
  end

  // Strictly greater wins, so on a tie the entry nearer the head stays.
  always_comb begin
    tok_d     = tok_i;
    tok_pos_d = tok_pos_i;
    if (occupied && (!tok_i.found || (own_score > tok_i.score))) begin
      tok_d     = '{found: 1'b1, score: own_score, id: entry_q.id};
      tok_pos_d = POS_W'(INDEX);
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q     <= '0;
      tok_pos_q <= '0;
    end else begin
      tok_q     <= tok_d;
      tok_pos_q <= tok_pos_d;
    end
  end

  assign entry_o   = entry_q;
  assign tok_o     = tok_q;
  assign tok_pos_o = tok_pos_q;

endmodule

// ----- hdl/aging_priority_ready_queue.sv -----
// Top level of the aging priority ready queue: control, count and the row of cells.
//
//   channel  direction  handshake            payload
//   in       input      in_valid_i/in_stall_o  apq_pkg::in_item_t
//   out      output     out_valid_o/out_stall_i apq_pkg::out_item_t
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i (policy)
//
// An enqueue or a round-robin dequeue passes from idle to the apply state, which
// registers its result; the input stalls until the queue is back in idle, so no new
// item is taken before the last is applied. A priority dequeue on a non-empty queue
// first scans, letting the best candidate ripple one cell per cycle to the last cell.
// Reset empties the queue and selects round-robin; stored entries are not cleared.
// A stalled output holds its result; the next item is taken but its update waits.
module aging_priority_ready_queue #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  apq_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output apq_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_data_i
);

  localparam int unsigned PosW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } state_e;

  state_e               state_q, state_d;
  apq_pkg::in_item_t    req_q;
  apq_pkg::policy_e     policy_q;
  logic [CntW-1:0]      count_q, count_d;
  logic [PosW-1:0]      scan_cnt_q, scan_cnt_d;
  logic                 out_valid_q, out_valid_d;
  apq_pkg::out_item_t   out_q, out_d;
  apq_pkg::cell_ctrl_t  ctrl;
  logic [PosW-1:0]      pick_pos;
  logic                 commit;
  logic                 in_xfer;
  logic                 full;

  apq_pkg::entry_t      entries [QUEUE_DEPTH];
  apq_pkg::token_t      toks    [QUEUE_DEPTH];
  logic [PosW-1:0]      tok_pos [QUEUE_DEPTH];

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    apq_pkg::entry_t  nxt;
    apq_pkg::token_t  tin;
    logic [PosW-1:0]  pin;
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = entries[g+1];
    end
    if (g == 0) begin : g_first
      assign tin = '0;
      assign pin = '0;
    end else begin : g_rest
      assign tin = toks[g-1];
      assign pin = tok_pos[g-1];
    end
    apq_cell #(
      .INDEX(g),
      .POS_W(PosW),
      .CNT_W(CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .pick_pos_i  (pick_pos),
      .count_i     (count_q),
      .next_entry_i(nxt),
      .entry_o     (entries[g]),
      .tok_i       (tin),
      .tok_pos_i   (pin),
      .tok_o       (toks[g]),
      .tok_pos_o   (tok_pos[g])
    );
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign commit      = (state_q == ST_APPLY) && (!out_valid_q || !out_stall_i);
  assign full        = (count_q == CntW'(QUEUE_DEPTH));

  always_comb begin
    state_d    = state_q;
    scan_cnt_d = scan_cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          // A priority dequeue waits for the candidate to reach the last cell.
          if ((in_data_i.action == apq_pkg::ACT_DEQUEUE) &&
              (policy_q == apq_pkg::POLICY_PRIO) && (count_q != '0)) begin
            state_d    = ST_SCAN;
            scan_cnt_d = PosW'(QUEUE_DEPTH - 1);
          end else begin
            state_d = ST_APPLY;
          end
        end
      end
      ST_SCAN: begin
        scan_cnt_d = scan_cnt_q - 1'b1;
        if (scan_cnt_q == '0) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.new_id   = req_q.thread_id;
    ctrl.new_prio = req_q.priority_req;
    pick_pos      = '0;
    count_d       = count_q;
    out_d         = out_q;
    out_valid_d   = out_valid_q && out_stall_i;
    if (commit) begin
      out_valid_d     = 1'b1;
      out_d.granted   = 1'b0;
      out_d.chosen_id = 8'd0;
      out_d.status    = apq_pkg::STATUS_OK;
      if (req_q.action == apq_pkg::ACT_ENQUEUE) begin
        if (full) begin
          out_d.status = apq_pkg::STATUS_FULL;
        end else begin
          ctrl.enq_en = 1'b1;
          count_d     = count_q + 1'b1;
        end
      end else if (count_q == '0) begin
        out_d.status = apq_pkg::STATUS_EMPTY;
      end else begin
        ctrl.deq_en   = 1'b1;
        count_d       = count_q - 1'b1;
        out_d.granted = 1'b1;
        if (policy_q == apq_pkg::POLICY_PRIO) begin
          ctrl.age_en     = 1'b1;
          pick_pos        = tok_pos[QUEUE_DEPTH-1];
          out_d.chosen_id = toks[QUEUE_DEPTH-1].id;
        end else begin
          out_d.chosen_id = entries[0].id;
        end
      end
      out_d.occupancy = 6'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      policy_q    <= apq_pkg::POLICY_RR;
      count_q     <= '0;
      scan_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_cnt_q  <= scan_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= apq_pkg::policy_e'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_xfer) begin
      req_q <= in_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_grant_pops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (req_q.action == apq_pkg::ACT_DEQUEUE) && (count_q != '0))
    |=> (count_q == $past(count_q) - 1'b1) && out_valid_o && out_data_o.granted)
    else $error("granted dequeue did not remove one entry");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && (req_q.action == apq_pkg::ACT_ENQUEUE) && full)
    |=> (out_data_o.status == apq_pkg::STATUS_FULL) && (count_q == $past(count_q)))
    else $error("enqueue on full queue changed the count");

  a_scan_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> $stable(count_q))
    else $error("queue changed during candidate scan");

endmodule

// ----- bench/aging_priority_ready_queue_test.sv -----
// Self-checking testbench for the aging priority ready queue under both removal policies.
module aging_priority_ready_queue_test;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS_PER_PHASE = 325;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  apq_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  apq_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_data = 1'b0;

  aging_priority_ready_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  apq_pkg::in_item_t  thread_requests[$];
  apq_pkg::out_item_t expected_grants[$];

  // Local copy of the ready queue and the selected policy.
  apq_pkg::entry_t  ready_q[QUEUE_DEPTH];
  int               ready_count = 0;
  apq_pkg::policy_e cur_policy = apq_pkg::POLICY_RR;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int grants_seen = 0;
  int prio_grants = 0;
  int full_drops = 0;
  int empty_misses = 0;
  int quiet_cycles = 0;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;
  wire cfg_fire = cfg_valid && cfg_ready;

  function automatic apq_pkg::out_item_t schedule_next(apq_pkg::in_item_t item);
    apq_pkg::out_item_t r;
    int                 pick;
    int                 i;
    logic [8:0]         best;
    logic [8:0]         score;
    r = '0;
    r.status = apq_pkg::STATUS_OK;
    if (item.action == apq_pkg::ACT_ENQUEUE) begin
      if (ready_count >= QUEUE_DEPTH) begin
        r.status = apq_pkg::STATUS_FULL;
      end else begin
        ready_q[ready_count] = '{id: item.thread_id, prio: item.priority_req, age: 8'd0};
        ready_count++;
      end
    end else if (ready_count == 0) begin
      r.status = apq_pkg::STATUS_EMPTY;
    end else begin
      pick = 0;
      if (cur_policy == apq_pkg::POLICY_PRIO) begin
        best = ready_q[0].prio + ready_q[0].age;
        for (i = 1; i < ready_count; i++) begin
          score = ready_q[i].prio + ready_q[i].age;
          // Strictly greater, so on a tie the entry nearest the head keeps the grant.
          if (score > best) begin
            best = score;
            pick = i;
          end
        end
      end
      r.granted = 1'b1;
      r.chosen_id = ready_q[pick].id;
      for (i = pick; i < ready_count - 1; i++) ready_q[i] = ready_q[i + 1];
      ready_count--;
      if (cur_policy == apq_pkg::POLICY_PRIO) begin
        for (i = 0; i < ready_count; i++) begin
          if (ready_q[i].age != 8'hFF) ready_q[i].age = ready_q[i].age + 8'd1;
        end
      end
    end
    r.occupancy = ready_count[5:0];
    return r;
  endfunction

  // Driver: when the input slot is free, loads the next request unless a random idle is drawn.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || !in_stall) begin
        if (thread_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= thread_requests.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results, predicts on each input transfer and drives the output stall.
  always @(posedge clk_i) begin : monitor
    apq_pkg::out_item_t exp_r;
    if (rst_ni) begin
      if (cfg_fire) cur_policy = apq_pkg::policy_e'(cfg_data);
      if (out_fire) begin
        if (expected_grants.size() == 0) begin
          $error("result with no request outstanding: %p", out_data);
          errors++;
        end else begin
          exp_r = expected_grants.pop_front();
          if (out_data.granted !== exp_r.granted) begin
            $error("granted: expected %0d, got %0d", exp_r.granted, out_data.granted);
            errors++;
          end
          if (out_data.chosen_id !== exp_r.chosen_id) begin
            $error("chosen_id: expected %0d, got %0d", exp_r.chosen_id, out_data.chosen_id);
            errors++;
          end
          if (out_data.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_data.status);
            errors++;
          end
          if (out_data.occupancy !== exp_r.occupancy) begin
            $error("occupancy: expected %0d, got %0d", exp_r.occupancy, out_data.occupancy);
            errors++;
          end
        end
      end
      if (in_fire) begin
        exp_r = schedule_next(in_data);
        expected_grants.push_back(exp_r);
        if (exp_r.granted) begin
          grants_seen++;
          if (cur_policy == apq_pkg::POLICY_PRIO) prio_grants++;
        end
        if (exp_r.status == apq_pkg::STATUS_FULL) full_drops++;
        if (exp_r.status == apq_pkg::STATUS_EMPTY) empty_misses++;
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire || out_fire || cfg_fire) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic apq_pkg::in_item_t make_item(apq_pkg::action_e act, logic [7:0] id,
                                                  logic [3:0] prio);
    apq_pkg::in_item_t it;
    it.action = act;
    it.thread_id = id;
    it.priority_req = prio;
    return it;
  endfunction

  task automatic write_policy(input apq_pkg::policy_e pol);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= pol;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (thread_requests.size() != 0 || in_valid || expected_grants.size() != 0);
  endtask

  // Bursts that lean toward enqueue or dequeue push the queue to full and to empty.
  task automatic queue_random_traffic(input int n_items);
    int                burst;
    int                enq_pct;
    int                k;
    apq_pkg::in_item_t it;
    while (n_items > 0) begin
      burst = $urandom_range(8, 48);
      case ($urandom_range(0, 2))
        0: enq_pct = 85;
        1: enq_pct = 15;
        default: enq_pct = 50;
      endcase
      for (k = 0; k < burst && n_items > 0; k++) begin
        it.action = ($urandom_range(0, 99) < enq_pct) ? apq_pkg::ACT_ENQUEUE
                                                      : apq_pkg::ACT_DEQUEUE;
        it.thread_id = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0) it.priority_req = $urandom_range(0, 1) ? 4'hF : 4'h0;
        else it.priority_req = 4'($urandom_range(0, 15));
        thread_requests.push_back(it);
        n_items--;
      end
    end
  endtask

  initial begin
    int mode;
    int pol;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Round-robin: empty dequeue, field extremes, head order.
    write_policy(apq_pkg::POLICY_RR);
    thread_requests.push_back(make_item(apq_pkg::ACT_DEQUEUE, 8'h00, 4'h0));
    thread_requests.push_back(make_item(apq_pkg::ACT_ENQUEUE, 8'hFF, 4'hF));
    thread_requests.push_back(make_item(apq_pkg::ACT_ENQUEUE, 8'h00, 4'h0));
    thread_requests.push_back(make_item(apq_pkg::ACT_ENQUEUE, 8'hA5, 4'h7));
    thread_requests.push_back(make_item(apq_pkg::ACT_DEQUEUE, 8'hFF, 4'hF));
    thread_requests.push_back(make_item(apq_pkg::ACT_DEQUEUE, 8'h00, 4'h0));
    thread_requests.push_back(make_item(apq_pkg::ACT_DEQUEUE, 8'h00, 4'h0));
    thread_requests.push_back(make_item(apq_pkg::ACT_DEQUEUE, 8'h00, 4'h0));
    wait_drained();

    // Priority mode: empty dequeue, highest score, tie broken toward the head, aging.
    write_policy(apq_pkg::POLICY_PRIO);
    thread_requests.push_back(make_item(apq_pkg::ACT_DEQUEUE, 8'h5A, 4'hF));
    thread_requests.push_back(make_item(apq_pkg::ACT_ENQUEUE, 8'h00, 4'h0));
    thread_requests.push_back(make_item(apq_pkg::ACT_ENQUEUE, 8'hFF, 4'hF));
    thread_requests.push_back(make_item(apq_pkg::ACT_ENQUEUE, 8'h12, 4'h9));
    thread_requests.push_back(make_item(apq_pkg::ACT_ENQUEUE, 8'h34, 4'h9));
    thread_requests.push_back(make_item(apq_pkg::ACT_DEQUEUE, 8'h00, 4'h0));
    thread_requests.push_back(make_item(apq_pkg::ACT_DEQUEUE, 8'h00, 4'h0));
    thread_requests.push_back(make_item(apq_pkg::ACT_ENQUEUE, 8'h56, 4'h2));
    thread_requests.push_back(make_item(apq_pkg::ACT_DEQUEUE, 8'h00, 4'h0));
    thread_requests.push_back(make_item(apq_pkg::ACT_DEQUEUE, 8'h00, 4'h0));
    thread_requests.push_back(make_item(apq_pkg::ACT_DEQUEUE, 8'h00, 4'h0));
    thread_requests.push_back(make_item(apq_pkg::ACT_DEQUEUE, 8'h00, 4'h0));
    wait_drained();

    for (mode = 0; mode < 3; mode++) begin
      for (pol = 0; pol < 2; pol++) begin
        case (mode)
          0: begin
            send_idle_pct = 17;
            recv_idle_pct = 77;
          end
          1: begin
            send_idle_pct = 77;
            recv_idle_pct = 17;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        write_policy(apq_pkg::policy_e'(pol));
        queue_random_traffic(RANDOM_ITEMS_PER_PHASE);
        wait_drained();
      end
    end

    repeat (QUEUE_DEPTH + 4) @(posedge clk_i);
    $display("covered: %0d grants (%0d by priority+age), %0d full drops, %0d empty dequeues",
             grants_seen, prio_grants, full_drops, empty_misses);
    $display("both policies ran under sender stalls, receiver stalls and back-to-back traffic");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/apq_pkg.sv
hdl/apq_cell.sv
hdl/aging_priority_ready_queue.sv
bench/aging_priority_ready_queue_test.sv
